// ===== src/tslt_pkg.sv =====
// ============================================================================
// tslt_pkg: shared types and constants for the straight-line trajectory
// Widths of the intermediate terms, register indexes, the configuration and
// law records passed between stages, and the output saturation helper.
// ============================================================================
package tslt_pkg;

    localparam int NAXES   = 3;
    localparam int XW      = 128;   // dividend: magnitude times scaled numerator
    localparam int DW      = 96;    // divisor: T^3 or blend products
    localparam int QW      = 32;    // quotient bits before rounding
    localparam int NS_W    = 96;
    localparam int NV_W    = 66;
    localparam int NVS_W   = 86;
    localparam int NA_W    = 35;
    localparam int NAS_W   = 75;
    localparam int DIV_LAT = QW + 2;
    localparam int SGN_LAT = DIV_LAT + 2;
    localparam int AXIS_LAT = DIV_LAT + 3;

    localparam logic [19:0] US_PER_S   = 20'd1000000;
    localparam logic [39:0] US2_PER_S2 = 40'd1000000000000;
    localparam logic [31:0] DUR_RESET  = 32'd1000000;

    typedef enum logic [2:0] {
        REG_DUR     = 3'd0,
        REG_BLEND   = 3'd1,
        REG_START_X = 3'd2,
        REG_START_Y = 3'd3,
        REG_START_Z = 3'd4,
        REG_END_X   = 3'd5,
        REG_END_Y   = 3'd6,
        REG_END_Z   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        RG_ACC,
        RG_CRUISE,
        RG_DEC,
        RG_PAST
    } t_region;

    typedef struct packed {
        logic [31:0]                 t_dur;
        logic [30:0]                 blend;
        logic [31:0]                 tmc;
        logic                        cubic;
        logic [63:0]                 d2;
        logic [DW-1:0]               den_pos;
        logic [DW-1:0]               den_vel;
        logic [NAXES-1:0][31:0]      mag;
        logic [NAXES-1:0]            dneg;
        logic [NAXES-1:0][31:0]      start;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [NS_W-1:0]   ns;
        logic [NVS_W-1:0]  nvs;
        logic [NAS_W-1:0]  nas;
        logic              aneg;
    } t_law;

    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        return 64'(a) * 64'(b);
    endfunction

    // clamp a 34-bit two's complement value to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic [33:0] v);
        logic [31:0] r;
        if (!v[33] && v[32:31] != 2'b00) begin
            r = 32'h7FFF_FFFF;
        end else if (v[33] && v[32:31] != 2'b11) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/tslt_cfg.sv =====
// ============================================================================
// tslt_cfg: configuration registers and derived constants
// Holds the written registers and derives the effective duration, clamped
// blend time, per-axis differences and the divisors, one level per cycle.
// ============================================================================
module tslt_cfg import tslt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    output t_cfg        o_cfg
);

    logic [31:0]            r_dur;
    logic [30:0]            r_blend;
    logic [NAXES-1:0][31:0] r_start;
    logic [NAXES-1:0][31:0] r_end;

    logic [31:0]            n_t;
    logic [31:0]            n_half;
    logic [30:0]            n_c;
    logic [32:0]            n_diff;
    logic [NAXES-1:0][31:0] n_mag;
    logic [NAXES-1:0]       n_dneg;
    logic [63:0]            n_ph;
    logic [63:0]            n_pl;

    logic [31:0]            r_t;
    logic [30:0]            r_c;
    logic [31:0]            r_tmc;
    logic                   r_cubic;
    logic [NAXES-1:0][31:0] r_mag;
    logic [NAXES-1:0]       r_dneg;
    logic [63:0]            r_t2;
    logic [63:0]            r_d;
    logic [DW-1:0]          r_t3;
    logic [63:0]            r_d2;
    logic [DW-1:0]          r_den_pos;
    logic [DW-1:0]          r_den_vel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur   <= DUR_RESET;
            r_blend <= '0;
            r_start <= '0;
            r_end   <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DUR:     r_dur      <= i_cfg_wdata;
                REG_BLEND:   r_blend    <= i_cfg_wdata[30:0];
                REG_START_X: r_start[0] <= i_cfg_wdata;
                REG_START_Y: r_start[1] <= i_cfg_wdata;
                REG_START_Z: r_start[2] <= i_cfg_wdata;
                REG_END_X:   r_end[0]   <= i_cfg_wdata;
                REG_END_Y:   r_end[1]   <= i_cfg_wdata;
                REG_END_Z:   r_end[2]   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_t    = (r_dur == '0) ? 32'd1 : r_dur;
        n_half = n_t >> 1;
        n_c    = (r_blend > n_half[30:0]) ? n_half[30:0] : r_blend;
        n_diff = '0;
        for (int a = 0; a < NAXES; a++) begin
            n_diff    = {r_end[a][31], r_end[a]} - {r_start[a][31], r_start[a]};
            n_dneg[a] = n_diff[32];
            n_mag[a]  = n_diff[32] ? 32'(-n_diff) : n_diff[31:0];
        end
        n_ph = mul32(r_t2[63:32], r_t);
        n_pl = mul32(r_t2[31:0], r_t);
    end

    // derived levels settle through a chain of registers after a write; items reach them later
    always_ff @(posedge i_clk) begin
        r_t       <= n_t;
        r_c       <= n_c;
        r_tmc     <= n_t - 32'(n_c);
        r_cubic   <= (n_c == '0);
        r_mag     <= n_mag;
        r_dneg    <= n_dneg;
        r_t2      <= mul32(r_t, r_t);
        r_d       <= mul32({1'b0, r_c}, r_tmc);
        r_t3      <= {n_ph, 32'b0} + {32'b0, n_pl};
        r_d2      <= {r_d[62:0], 1'b0};
        r_den_pos <= r_cubic ? r_t3 : DW'(r_d2);
        r_den_vel <= r_cubic ? r_t3 : DW'(r_d);
    end

    always_comb begin
        o_cfg.t_dur   = r_t;
        o_cfg.blend   = r_c;
        o_cfg.tmc     = r_tmc;
        o_cfg.cubic   = r_cubic;
        o_cfg.d2      = r_d2;
        o_cfg.den_pos = r_den_pos;
        o_cfg.den_vel = r_den_vel;
        o_cfg.mag     = r_mag;
        o_cfg.dneg    = r_dneg;
        o_cfg.start   = r_start;
    end

endmodule

// ===== src/tslt_law.sv =====
// ============================================================================
// tslt_law: timing law numerators
// Five-stage pipeline from sample time to the numerators of s, s' and s''
// (already scaled to seconds) for either the cubic or the trapezoidal law.
// ============================================================================
module tslt_law import tslt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_sample_time,
    input  t_cfg        i_cfg,
    output t_law        o_law
);

    logic        r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [31:0] r_t1;

    logic [31:0] n_tt;
    logic [31:0] n_tmt;
    logic [33:0] n_m3;
    logic [32:0] n_tt2x;
    logic        n_aneg;
    logic [32:0] n_am;
    logic [32:0] n_w;
    t_region     n_rg;

    logic [31:0] r_tt_2, r_tmt_2;
    logic [33:0] r_m3_2;
    logic [32:0] r_am_2, r_w_2;
    logic        r_aneg_2;
    t_region     r_rg_2;

    logic [63:0] r_sq_3, r_ttm_3, r_u2_3, r_cw_3;
    logic [31:0] r_tt_3, r_tmt_3;
    logic [33:0] r_m3_3;
    logic [32:0] r_am_3;
    logic        r_aneg_3;
    t_region     r_rg_3;

    logic [65:0]     n_nslo, n_nshi;
    logic [63:0]     n_nstr;
    logic [NV_W-1:0] n_nv;
    logic [NA_W-1:0] n_na;
    logic            n_aneg3;

    logic [65:0]     r_nslo_4, r_nshi_4;
    logic [63:0]     r_nstr_4;
    logic [NV_W-1:0] r_nv_4;
    logic [NA_W-1:0] r_na_4;
    logic            r_aneg_4;

    logic [NS_W-1:0]  r_ns_5;
    logic [NVS_W-1:0] r_nvs_5;
    logic [NAS_W-1:0] r_nas_5;
    logic             r_aneg_5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: clamp time, pick the trapezoid phase
    always_comb begin
        n_tt   = (r_t1 < i_cfg.t_dur) ? r_t1 : i_cfg.t_dur;
        n_tmt  = i_cfg.t_dur - n_tt;
        n_m3   = {2'b00, i_cfg.t_dur} + {1'b0, i_cfg.t_dur, 1'b0} - {1'b0, n_tt, 1'b0};
        n_tt2x = {n_tt, 1'b0};
        n_aneg = n_tt2x > {1'b0, i_cfg.t_dur};
        n_am   = n_aneg ? n_tt2x - {1'b0, i_cfg.t_dur} : {1'b0, i_cfg.t_dur} - n_tt2x;
        n_w    = {r_t1, 1'b0} - {2'b00, i_cfg.blend};
        if (r_t1 <= {1'b0, i_cfg.blend}) begin
            n_rg = RG_ACC;
        end else if (r_t1 <= i_cfg.tmc) begin
            n_rg = RG_CRUISE;
        end else if (r_t1 <= i_cfg.t_dur) begin
            n_rg = RG_DEC;
        end else begin
            n_rg = RG_PAST;
        end
    end

    // stage 3: select trapezoid terms, split the cubic product
    always_comb begin
        n_nslo = 66'(r_sq_3[31:0]) * 66'(r_m3_3);
        n_nshi = 66'(r_sq_3[63:32]) * 66'(r_m3_3);
        case (r_rg_3)
            RG_ACC:    n_nstr = r_sq_3;
            RG_CRUISE: n_nstr = r_cw_3;
            RG_DEC:    n_nstr = i_cfg.d2 - r_u2_3;
            default:   n_nstr = i_cfg.d2;
        endcase
        if (i_cfg.cubic) begin
            n_nv    = NV_W'({r_ttm_3, 2'b00}) + NV_W'({r_ttm_3, 1'b0});
            n_na    = NA_W'({r_am_3, 2'b00}) + NA_W'({r_am_3, 1'b0});
            n_aneg3 = r_aneg_3;
        end else begin
            case (r_rg_3)
                RG_ACC:    n_nv = NV_W'(r_tt_3);
                RG_CRUISE: n_nv = NV_W'(i_cfg.blend);
                RG_DEC:    n_nv = NV_W'(r_tmt_3);
                default:   n_nv = '0;
            endcase
            n_na    = (r_rg_3 inside {RG_ACC, RG_DEC}) ? NA_W'(1) : '0;
            n_aneg3 = (r_rg_3 == RG_DEC);
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1     <= i_sample_time;

        r_tt_2   <= n_tt;
        r_tmt_2  <= n_tmt;
        r_m3_2   <= n_m3;
        r_am_2   <= n_am;
        r_aneg_2 <= n_aneg;
        r_w_2    <= n_w;
        r_rg_2   <= n_rg;

        r_sq_3   <= mul32(r_tt_2, r_tt_2);
        r_ttm_3  <= mul32(r_tt_2, r_tmt_2);
        r_u2_3   <= mul32(r_tmt_2, r_tmt_2);
        r_cw_3   <= 64'(64'(i_cfg.blend) * 64'(r_w_2));
        r_tt_3   <= r_tt_2;
        r_tmt_3  <= r_tmt_2;
        r_m3_3   <= r_m3_2;
        r_am_3   <= r_am_2;
        r_aneg_3 <= r_aneg_2;
        r_rg_3   <= r_rg_2;

        r_nslo_4 <= n_nslo;
        r_nshi_4 <= n_nshi;
        r_nstr_4 <= n_nstr;
        r_nv_4   <= n_nv;
        r_na_4   <= n_na;
        r_aneg_4 <= n_aneg3;

        // scale velocity to per second and acceleration to per second squared
        r_ns_5   <= i_cfg.cubic ? NS_W'({r_nshi_4, 32'b0}) + NS_W'(r_nslo_4)
                                : NS_W'(r_nstr_4);
        r_nvs_5  <= NVS_W'(r_nv_4) * NVS_W'(US_PER_S);
        r_nas_5  <= NAS_W'(r_na_4) * NAS_W'(US2_PER_S2);
        r_aneg_5 <= r_aneg_4;
    end

    always_comb begin
        o_law.valid = r_v5;
        o_law.ns    = r_ns_5;
        o_law.nvs   = r_nvs_5;
        o_law.nas   = r_nas_5;
        o_law.aneg  = r_aneg_5;
    end

endmodule

// ===== src/tslt_div.sv =====
// ============================================================================
// tslt_div: pipelined rounding divider
// One quotient bit per stage; overflow past the quotient width saturates.
// Result is round(x / den), halves rounded up, 33 bits.
// ============================================================================
module tslt_div import tslt_pkg::*; (
    input  logic          i_clk,
    input  logic [XW-1:0] i_x,
    input  logic [DW-1:0] i_den,
    output logic [QW:0]   o_q
);

    logic [DW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_xl  [0:QW];
    logic [QW-1:0] r_qt  [0:QW];
    logic          r_ovf [0:QW];
    logic [QW:0]   r_q;
    logic          n_rnd;

    // quotient fits in QW bits only when the high part is below the divisor
    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_x[XW-1:QW];
        r_xl[0]  <= i_x[QW-1:0];
        r_qt[0]  <= '0;
        r_ovf[0] <= (i_x[XW-1:QW] >= i_den);
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0] n_shift;
        logic        n_ge;

        always_comb begin
            n_shift = {r_rem[k-1], r_xl[k-1][QW-1]};
            n_ge    = (n_shift >= {1'b0, i_den});
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_ge ? DW'(n_shift - {1'b0, i_den}) : n_shift[DW-1:0];
            r_xl[k]  <= {r_xl[k-1][QW-2:0], 1'b0};
            r_qt[k]  <= {r_qt[k-1][QW-2:0], n_ge};
            r_ovf[k] <= r_ovf[k-1];
        end
    end

    assign n_rnd = ({r_rem[QW], 1'b0} >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        r_q <= r_ovf[QW] ? {1'b1, QW'(0)} : {1'b0, r_qt[QW]} + (QW+1)'(n_rnd);
    end

    assign o_q = r_q;

endmodule

// ===== src/tslt_axis.sv =====
// ============================================================================
// tslt_axis: one coordinate axis
// Multiplies the law numerators by the axis difference, divides by the law
// denominators, applies the sign, adds the start point and saturates.
// ============================================================================
module tslt_axis import tslt_pkg::*; (
    input  logic          i_clk,
    input  t_law          i_law,
    input  logic [31:0]   i_mag,
    input  logic          i_dneg,
    input  logic [31:0]   i_start,
    input  logic [DW-1:0] i_den_pos,
    input  logic [DW-1:0] i_den_vel,
    output logic [31:0]   o_pos,
    output logic [31:0]   o_vel,
    output logic [31:0]   o_acc
);

    logic [63:0]   r_pp  [0:2][0:2];
    logic [XW-1:0] r_x   [0:2];
    logic [1:0]    r_sgn [0:SGN_LAT-1];

    logic [QW:0]   q_pos, q_vel, q_acc;
    logic [33:0]   n_pv, n_vv, n_av;
    logic [31:0]   r_pos, r_vel, r_acc;

    always_ff @(posedge i_clk) begin
        r_pp[0][0] <= mul32(i_law.ns[31:0], i_mag);
        r_pp[0][1] <= mul32(i_law.ns[63:32], i_mag);
        r_pp[0][2] <= mul32(i_law.ns[95:64], i_mag);
        r_pp[1][0] <= mul32(i_law.nvs[31:0], i_mag);
        r_pp[1][1] <= mul32(i_law.nvs[63:32], i_mag);
        r_pp[1][2] <= mul32(32'(i_law.nvs[NVS_W-1:64]), i_mag);
        r_pp[2][0] <= mul32(i_law.nas[31:0], i_mag);
        r_pp[2][1] <= mul32(i_law.nas[63:32], i_mag);
        r_pp[2][2] <= mul32(32'(i_law.nas[NAS_W-1:64]), i_mag);
        r_sgn[0]   <= {i_dneg, i_dneg ^ i_law.aneg};
        for (int j = 0; j < 3; j++) begin
            r_x[j] <= (XW'(r_pp[j][2]) << 64) + (XW'(r_pp[j][1]) << 32) + XW'(r_pp[j][0]);
        end
        for (int k = 1; k < SGN_LAT; k++) begin
            r_sgn[k] <= r_sgn[k-1];
        end
    end

    tslt_div u_div_pos (.i_clk(i_clk), .i_x(r_x[0]), .i_den(i_den_pos), .o_q(q_pos));
    tslt_div u_div_vel (.i_clk(i_clk), .i_x(r_x[1]), .i_den(i_den_vel), .o_q(q_vel));
    tslt_div u_div_acc (.i_clk(i_clk), .i_x(r_x[2]), .i_den(i_den_vel), .o_q(q_acc));

    always_comb begin
        n_pv = r_sgn[SGN_LAT-1][1] ? -{1'b0, q_pos} : {1'b0, q_pos};
        n_vv = r_sgn[SGN_LAT-1][1] ? -{1'b0, q_vel} : {1'b0, q_vel};
        n_av = r_sgn[SGN_LAT-1][0] ? -{1'b0, q_acc} : {1'b0, q_acc};
    end

    always_ff @(posedge i_clk) begin
        r_pos <= sat32({{2{i_start[31]}}, i_start} + n_pv);
        r_vel <= sat32(n_vv);
        r_acc <= sat32(n_av);
    end

    assign o_pos = r_pos;
    assign o_vel = r_vel;
    assign o_acc = r_acc;

endmodule

// ===== src/time_scaled_linear_trajectory.sv =====
// ============================================================================
// time_scaled_linear_trajectory: straight-line setpoint generator
// Position, velocity and acceleration on a segment for a given sample time,
// with a trapezoidal or cubic timing law, in saturated Q16.16.
// ============================================================================
// A sample is taken on every clock edge where start is high; busy is always
// low, so one sample per cycle is sustained. Each result appears on the
// output ports with o_valid high for exactly one cycle, in sample order;
// the receiver must take it then. The per-axis dividers resolve one
// quotient bit per pipeline stage. Write configuration only when no
// sample is in flight.
module time_scaled_linear_trajectory import tslt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_sample_time,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_valid,
    output logic [31:0] o_pos_x,
    output logic [31:0] o_pos_y,
    output logic [31:0] o_pos_z,
    output logic [31:0] o_vel_x,
    output logic [31:0] o_vel_y,
    output logic [31:0] o_vel_z,
    output logic [31:0] o_acc_x,
    output logic [31:0] o_acc_y,
    output logic [31:0] o_acc_z
);

    t_cfg                   cfg;
    t_law                   law;
    logic [NAXES-1:0][31:0] pos_q, vel_q, acc_q;
    logic [AXIS_LAT-1:0]    r_vp;

    assign busy = 1'b0;

    tslt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tslt_law u_law (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start & ~busy),
        .i_sample_time (i_sample_time),
        .i_cfg         (cfg),
        .o_law         (law)
    );

    for (genvar a = 0; a < NAXES; a++) begin : g_axis
        tslt_axis u_axis (
            .i_clk     (i_clk),
            .i_law     (law),
            .i_mag     (cfg.mag[a]),
            .i_dneg    (cfg.dneg[a]),
            .i_start   (cfg.start[a]),
            .i_den_pos (cfg.den_pos),
            .i_den_vel (cfg.den_vel),
            .o_pos     (pos_q[a]),
            .o_vel     (vel_q[a]),
            .o_acc     (acc_q[a])
        );
    end

    // advance the valid flag alongside the axis datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else begin
            r_vp <= {r_vp[AXIS_LAT-2:0], law.valid};
        end
    end

    assign o_valid = r_vp[AXIS_LAT-1];
    assign o_pos_x = pos_q[0];
    assign o_pos_y = pos_q[1];
    assign o_pos_z = pos_q[2];
    assign o_vel_x = vel_q[0];
    assign o_vel_y = vel_q[1];
    assign o_vel_z = vel_q[2];
    assign o_acc_x = acc_q[0];
    assign o_acc_y = acc_q[1];
    assign o_acc_z = acc_q[2];

endmodule
